[rtl/i2cblm_pkg.sv]
// Shared types and constants for the I2C bit-level master.
package i2cblm_pkg;

   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_STOP  = 2'd1,
      CMD_WRITE = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   // transaction kind carried on tuser
   localparam logic KIND_COMMAND = 1'b0;
   localparam logic KIND_TICK    = 1'b1;

   // bit positions within the line drive register
   localparam int LINE_SCL = 0;
   localparam int LINE_SDA = 1;
   localparam int LINE_OE  = 2;

   localparam logic [2:0] LINES_RESET = 3'b111;

   // phases per command
   localparam logic [5:0] PHASES_START = 6'd3;
   localparam logic [5:0] PHASES_STOP  = 6'd3;
   localparam logic [5:0] PHASES_WRITE = 6'd27;
   localparam logic [5:0] PHASES_READ  = 6'd20;

   // write phases: 8 bits of three phases each, then the ack slot
   localparam logic [5:0] WR_ACK_RELEASE = 6'd24;
   localparam logic [5:0] WR_ACK_HIGH    = 6'd25;

   // read phases: release, SCL half-periods for the eight data bits, then the ack slot
   localparam logic [5:0] RD_RELEASE   = 6'd0;
   localparam logic [5:0] RD_ACK_DRIVE = 6'd17;
   localparam logic [5:0] RD_ACK_HIGH  = 6'd18;

   localparam logic [7:0] MSB_MASK = 8'h80;

   localparam logic [15:0] DELAY_RESET = 16'd1;

endpackage

[rtl/i2c_bit_level_master.sv]
// I2C bit-level master: timed bus phases for start, stop, write byte and read byte.

// Takes one transaction per clock, commands and ticks alike, and returns one result
// for each, registered in the cycle after acceptance. The only limit on rate is the
// single output register: req_tready is high while that register is empty or is
// being emptied in the same cycle, so a stalled rsp side stalls the req side
// directly. Each command is a fixed list of phases (start 3, stop 3, write 27,
// read 20); each phase lasts csr ticks_per_delay tick transactions (0 counts as 1),
// and the new line levels of a phase appear in the result of the tick that ends
// the previous one. A command that arrives while one is running is flagged as
// rejected and otherwise ignored. No other configuration or start-up pass is needed.
module i2c_bit_level_master (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [1:0] command, [9:2] write_byte, [10] ack_select, [11] sda_in, [15:12] zero
   input  logic [15:0] req_tdata,
   // [0] kind
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] scl_out, [1] sda_out, [2] sda_drive, [3] busy_res, [4] done_res,
   // [5] ack_received, [13:6] read_data, [14] rejected, [15] zero
   output logic [15:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);

   logic                 delay_zero;
   logic [15:0]          tpd_ff;
   logic [5:0]           phase_ff, phase_in;
   i2cblm_pkg::cmd_type  cmd_ff, cmd_in;
   logic                 active_ff, active_in;
   logic [7:0]           shift_ff, shift_in;
   logic [15:0]          delay_ff, delay_in;
   logic                 ack_choice_ff, ack_choice_in;
   logic [2:0]           lines_ff, lines_in;
   logic                 ack_seen_ff, ack_seen_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [15:0]          rsp_data_ff, rsp_data_in;

   logic                 accept;
   logic                 req_kind;
   i2cblm_pkg::cmd_type  req_cmd;
   logic [7:0]           req_byte;
   logic                 req_ack;
   logic                 req_sda;
   logic [15:0]          limit;
   logic [15:0]          count_next;
   logic [5:0]           phase_next;
   logic                 done;
   logic                 rejected;
   logic                 ack_out;
   logic [7:0]           data_out;

   function automatic logic [5:0] phase_total(input i2cblm_pkg::cmd_type cmd);
      logic [5:0] total;
      unique case (cmd)
         i2cblm_pkg::CMD_START: total = i2cblm_pkg::PHASES_START;
         i2cblm_pkg::CMD_STOP:  total = i2cblm_pkg::PHASES_STOP;
         i2cblm_pkg::CMD_WRITE: total = i2cblm_pkg::PHASES_WRITE;
         i2cblm_pkg::CMD_READ:  total = i2cblm_pkg::PHASES_READ;
         default:               total = i2cblm_pkg::PHASES_START;
      endcase
      return total;
   endfunction

   // bit number within the byte for write phases below the ack slot
   function automatic logic [2:0] write_bitno(input logic [5:0] p);
      logic [2:0] bitno;
      case (p) inside
         [6'd0:6'd2]:   bitno = 3'd0;
         [6'd3:6'd5]:   bitno = 3'd1;
         [6'd6:6'd8]:   bitno = 3'd2;
         [6'd9:6'd11]:  bitno = 3'd3;
         [6'd12:6'd14]: bitno = 3'd4;
         [6'd15:6'd17]: bitno = 3'd5;
         [6'd18:6'd20]: bitno = 3'd6;
         default:       bitno = 3'd7;
      endcase
      return bitno;
   endfunction

   // line levels on entry to phase p
   function automatic logic [2:0] enter_phase(
      input i2cblm_pkg::cmd_type cmd,
      input logic [5:0]          p,
      input logic [7:0]          shift,
      input logic                ack_choice,
      input logic [2:0]          lines
   );
      logic [2:0] l;
      logic [2:0] bitno;
      logic [5:0] sub;
      logic [7:0] shifted;
      l       = lines;
      bitno   = write_bitno(p);
      sub     = p - 6'({bitno, 1'b0}) - 6'(bitno);
      shifted = (shift << bitno) & i2cblm_pkg::MSB_MASK;
      unique case (cmd)
         i2cblm_pkg::CMD_START: begin
            if (p == 6'd0) begin
               l = i2cblm_pkg::LINES_RESET;
            end else if (p == 6'd1) begin
               l[i2cblm_pkg::LINE_SDA] = 1'b0;
            end else begin
               l[i2cblm_pkg::LINE_SCL] = 1'b0;
            end
         end
         i2cblm_pkg::CMD_STOP: begin
            if (p == 6'd0) begin
               l[i2cblm_pkg::LINE_SDA] = 1'b0;
               l[i2cblm_pkg::LINE_OE]  = 1'b1;
               l[i2cblm_pkg::LINE_SCL] = 1'b0;
            end else if (p == 6'd1) begin
               l[i2cblm_pkg::LINE_SCL] = 1'b1;
            end else begin
               l[i2cblm_pkg::LINE_SDA] = 1'b1;
            end
         end
         i2cblm_pkg::CMD_WRITE: begin
            if (p < i2cblm_pkg::WR_ACK_RELEASE) begin
               if (sub == 6'd0) begin
                  l[i2cblm_pkg::LINE_OE]  = 1'b1;
                  l[i2cblm_pkg::LINE_SDA] = (shifted != 8'd0);
               end else if (sub == 6'd1) begin
                  l[i2cblm_pkg::LINE_SCL] = 1'b1;
               end else begin
                  l[i2cblm_pkg::LINE_SCL] = 1'b0;
               end
            end else if (p == i2cblm_pkg::WR_ACK_RELEASE) begin
               l[i2cblm_pkg::LINE_OE]  = 1'b0;
               l[i2cblm_pkg::LINE_SDA] = 1'b1;
            end else if (p == i2cblm_pkg::WR_ACK_HIGH) begin
               l[i2cblm_pkg::LINE_SCL] = 1'b1;
            end else begin
               l[i2cblm_pkg::LINE_SCL] = 1'b0;
            end
         end
         i2cblm_pkg::CMD_READ: begin
            if (p == i2cblm_pkg::RD_RELEASE) begin
               l[i2cblm_pkg::LINE_OE]  = 1'b0;
               l[i2cblm_pkg::LINE_SDA] = 1'b1;
            end else if (p < i2cblm_pkg::RD_ACK_DRIVE) begin
               l[i2cblm_pkg::LINE_SCL] = p[0];
            end else if (p == i2cblm_pkg::RD_ACK_DRIVE) begin
               l[i2cblm_pkg::LINE_OE]  = 1'b1;
               l[i2cblm_pkg::LINE_SDA] = ~ack_choice;
            end else if (p == i2cblm_pkg::RD_ACK_HIGH) begin
               l[i2cblm_pkg::LINE_SCL] = 1'b1;
            end else begin
               l[i2cblm_pkg::LINE_SCL] = 1'b0;
            end
         end
         default: l = lines;
      endcase
      return l;
   endfunction

   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign accept     = req_tvalid & req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign req_kind = req_tuser;
   assign req_cmd  = i2cblm_pkg::cmd_type'(req_tdata[1:0]);
   assign req_byte = req_tdata[9:2];
   assign req_ack  = req_tdata[10];
   assign req_sda  = req_tdata[11];

   assign delay_zero = (tpd_ff == 16'd0);
   assign limit      = delay_zero ? 16'd1 : tpd_ff;
   assign count_next = delay_ff + 16'd1;
   assign phase_next = phase_ff + 6'd1;

   always_comb begin
      phase_in      = phase_ff;
      cmd_in        = cmd_ff;
      active_in     = active_ff;
      shift_in      = shift_ff;
      delay_in      = delay_ff;
      ack_choice_in = ack_choice_ff;
      lines_in      = lines_ff;
      ack_seen_in   = ack_seen_ff;
      done          = 1'b0;
      rejected      = 1'b0;
      ack_out       = 1'b0;
      data_out      = 8'd0;

      if (req_kind == i2cblm_pkg::KIND_COMMAND) begin
         if (active_ff) begin
            rejected = 1'b1;
         end else begin
            active_in     = 1'b1;
            cmd_in        = req_cmd;
            phase_in      = 6'd0;
            delay_in      = 16'd0;
            ack_choice_in = req_ack;
            ack_seen_in   = 1'b0;
            shift_in      = (req_cmd == i2cblm_pkg::CMD_WRITE) ? req_byte : 8'd0;
            lines_in      = enter_phase(req_cmd, 6'd0, shift_in, req_ack, lines_ff);
         end
      end else if (active_ff) begin
         delay_in = count_next;
         if (count_next >= limit) begin
            // samples are taken on the tick that closes an SCL-high phase
            if (cmd_ff == i2cblm_pkg::CMD_WRITE && phase_ff == i2cblm_pkg::WR_ACK_HIGH) begin
               ack_seen_in = ~req_sda;
            end
            if (cmd_ff == i2cblm_pkg::CMD_READ && phase_ff[0] &&
                phase_ff < i2cblm_pkg::RD_ACK_DRIVE) begin
               shift_in = {shift_ff[6:0], req_sda};
            end
            delay_in = 16'd0;
            if (phase_next >= phase_total(cmd_ff)) begin
               active_in = 1'b0;
               phase_in  = 6'd0;
               done      = 1'b1;
               if (cmd_ff == i2cblm_pkg::CMD_WRITE) begin
                  ack_out = ack_seen_in;
               end
               if (cmd_ff == i2cblm_pkg::CMD_READ) begin
                  data_out = shift_in;
               end
            end else begin
               phase_in = phase_next;
               lines_in = enter_phase(cmd_ff, phase_next, shift_in, ack_choice_ff, lines_ff);
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {1'b0, rejected, data_out, ack_out, done, active_in,
                         lines_in[i2cblm_pkg::LINE_OE], lines_in[i2cblm_pkg::LINE_SDA],
                         lines_in[i2cblm_pkg::LINE_SCL]};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tpd_ff        <= i2cblm_pkg::DELAY_RESET;
         phase_ff      <= 6'd0;
         cmd_ff        <= i2cblm_pkg::CMD_START;
         active_ff     <= 1'b0;
         shift_ff      <= 8'd0;
         delay_ff      <= 16'd0;
         ack_choice_ff <= 1'b0;
         lines_ff      <= i2cblm_pkg::LINES_RESET;
         ack_seen_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            tpd_ff <= csr_wdata;
         end
         if (accept) begin
            phase_ff      <= phase_in;
            cmd_ff        <= cmd_in;
            active_ff     <= active_in;
            shift_ff      <= shift_in;
            delay_ff      <= delay_in;
            ack_choice_ff <= ack_choice_in;
            lines_ff      <= lines_in;
            ack_seen_ff   <= ack_seen_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   // a finished command no longer reports busy
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[4]) |-> !rsp_data_ff[3])
      else $error("done reported while still busy");

   // a rejected command never completes anything on the same transaction
   a_reject_no_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[14]) |-> (!rsp_data_ff[4] && rsp_data_ff[3]))
      else $error("rejected transaction also finished or went idle");

   a_phase_in_range: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (phase_ff < phase_total(cmd_ff)))
      else $error("phase index past end of command");

   a_idle_phase_zero: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> (phase_ff == 6'd0 && delay_ff == 16'd0))
      else $error("idle engine holds a stale phase or delay count");

   // delay count stays below the phase limit while running, unless the delay register was just written
   a_delay_below_limit: assert property (@(posedge clock) disable iff (reset)
      (active_ff && $stable(tpd_ff)) |-> (delay_ff < limit || $past(csr_we)))
      else $error("delay count at or above phase limit");
`endif

endmodule

[tb/sv/i2cblm_checker.sv]
// Checker for the I2C bit-level master: predicts every result and compares it.
`timescale 1ns / 100ps

module i2cblm_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata,
   output int          fail_count,
   output int          pending,
   output logic        engine_busy,
   output int          done_count,
   output int          reject_count
);

   // lowest bit last, so a cast from rsp_tdata lines up with the port layout
   typedef struct packed {
      logic       pad;
      logic       rejected;
      logic [7:0] rdata;
      logic       ack;
      logic       done;
      logic       busy;
      logic       oe;
      logic       sda;
      logic       scl;
   } line_rsp_type;

   localparam int BIT_PHASES = 3;
   localparam int PRINT_LIMIT = 40;

   line_rsp_type        line_expect_q[$];
   line_rsp_type        got, exp_r;

   logic [15:0]         delay_cfg;
   logic [5:0]          phase;
   i2cblm_pkg::cmd_type act_cmd;
   logic                running;
   logic [7:0]          shreg;
   logic [15:0]         dly;
   logic                ack_pick;
   logic [2:0]          lines;
   logic                ack_got;
   int                  fails, n_done, n_rej;

   task automatic report_mismatch(input string what, input logic [15:0] g,
                                  input logic [15:0] e);
      if (fails < PRINT_LIMIT)
         $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, g, e);
      fails++;
   endtask

   function automatic logic [5:0] phase_count(input i2cblm_pkg::cmd_type c);
      case (c)
         i2cblm_pkg::CMD_WRITE: return i2cblm_pkg::PHASES_WRITE;
         i2cblm_pkg::CMD_READ:  return i2cblm_pkg::PHASES_READ;
         i2cblm_pkg::CMD_STOP:  return i2cblm_pkg::PHASES_STOP;
         default:               return i2cblm_pkg::PHASES_START;
      endcase
   endfunction

   // line levels set on entry to phase p of command c
   function automatic logic [2:0] phase_lines(input i2cblm_pkg::cmd_type c,
                                              input logic [5:0] p,
                                              input logic [2:0] cur, input logic [7:0] sh,
                                              input logic ackp);
      logic [2:0] ln;
      int         bitno;
      ln = cur;
      bitno = p / BIT_PHASES;
      case (c)
         i2cblm_pkg::CMD_START: begin
            if (p == 0) ln = i2cblm_pkg::LINES_RESET;
            else if (p == 1) ln[i2cblm_pkg::LINE_SDA] = 1'b0;
            else ln[i2cblm_pkg::LINE_SCL] = 1'b0;
         end
         i2cblm_pkg::CMD_STOP: begin
            if (p == 0) begin
               ln[i2cblm_pkg::LINE_SDA] = 1'b0;
               ln[i2cblm_pkg::LINE_OE]  = 1'b1;
               ln[i2cblm_pkg::LINE_SCL] = 1'b0;
            end else if (p == 1) ln[i2cblm_pkg::LINE_SCL] = 1'b1;
            else ln[i2cblm_pkg::LINE_SDA] = 1'b1;
         end
         i2cblm_pkg::CMD_WRITE: begin
            if (p < i2cblm_pkg::WR_ACK_RELEASE) begin
               case (p % BIT_PHASES)
                  0: begin
                     ln[i2cblm_pkg::LINE_OE]  = 1'b1;
                     ln[i2cblm_pkg::LINE_SDA] = ((sh << bitno) & i2cblm_pkg::MSB_MASK) != 8'd0;
                  end
                  1: ln[i2cblm_pkg::LINE_SCL] = 1'b1;
                  default: ln[i2cblm_pkg::LINE_SCL] = 1'b0;
               endcase
            end else if (p == i2cblm_pkg::WR_ACK_RELEASE) begin
               ln[i2cblm_pkg::LINE_OE]  = 1'b0;
               ln[i2cblm_pkg::LINE_SDA] = 1'b1;
            end else if (p == i2cblm_pkg::WR_ACK_HIGH) ln[i2cblm_pkg::LINE_SCL] = 1'b1;
            else ln[i2cblm_pkg::LINE_SCL] = 1'b0;
         end
         default: begin
            if (p == i2cblm_pkg::RD_RELEASE) begin
               ln[i2cblm_pkg::LINE_OE]  = 1'b0;
               ln[i2cblm_pkg::LINE_SDA] = 1'b1;
            end else if (p < i2cblm_pkg::RD_ACK_DRIVE) ln[i2cblm_pkg::LINE_SCL] = p[0];
            else if (p == i2cblm_pkg::RD_ACK_DRIVE) begin
               ln[i2cblm_pkg::LINE_OE]  = 1'b1;
               ln[i2cblm_pkg::LINE_SDA] = ~ackp;
            end else if (p == i2cblm_pkg::RD_ACK_HIGH) ln[i2cblm_pkg::LINE_SCL] = 1'b1;
            else ln[i2cblm_pkg::LINE_SCL] = 1'b0;
         end
      endcase
      return ln;
   endfunction

   // one accepted transaction moves the engine on and queues the line state it reports
   task automatic advance_engine(input logic kind, input logic [15:0] data);
      i2cblm_pkg::cmd_type c;
      logic [7:0]          tx_byte;
      logic                ack_in, rx_sda;
      logic [15:0]         lim;
      line_rsp_type        r;
      c = i2cblm_pkg::cmd_type'(data[1:0]);
      tx_byte = data[9:2];
      ack_in = data[10];
      rx_sda = data[11];
      r = '0;
      if (kind == i2cblm_pkg::KIND_COMMAND) begin
         if (running) begin
            r.rejected = 1'b1;
            n_rej++;
         end else begin
            running  = 1'b1;
            act_cmd  = c;
            phase    = '0;
            dly      = '0;
            ack_pick = ack_in;
            ack_got  = 1'b0;
            shreg    = (c == i2cblm_pkg::CMD_WRITE) ? tx_byte : 8'd0;
            lines    = phase_lines(c, phase, lines, shreg, ack_pick);
         end
      end else if (running) begin
         lim = (delay_cfg == 16'd0) ? 16'd1 : delay_cfg;
         dly = dly + 16'd1;
         if (dly >= lim) begin
            // slave ack and read bits are taken at the close of an SCL-high phase
            if (act_cmd == i2cblm_pkg::CMD_WRITE && phase == i2cblm_pkg::WR_ACK_HIGH)
               ack_got = ~rx_sda;
            if (act_cmd == i2cblm_pkg::CMD_READ && phase > i2cblm_pkg::RD_RELEASE &&
                phase < i2cblm_pkg::RD_ACK_DRIVE && phase[0])
               shreg = {shreg[6:0], rx_sda};
            dly = '0;
            phase = phase + 6'd1;
            if (phase >= phase_count(act_cmd)) begin
               running = 1'b0;
               phase = '0;
               r.done = 1'b1;
               n_done++;
               if (act_cmd == i2cblm_pkg::CMD_WRITE) r.ack = ack_got;
               if (act_cmd == i2cblm_pkg::CMD_READ) r.rdata = shreg;
            end else begin
               lines = phase_lines(act_cmd, phase, lines, shreg, ack_pick);
            end
         end
      end
      r.scl  = lines[i2cblm_pkg::LINE_SCL];
      r.sda  = lines[i2cblm_pkg::LINE_SDA];
      r.oe   = lines[i2cblm_pkg::LINE_OE];
      r.busy = running;
      line_expect_q.push_back(r);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         delay_cfg = i2cblm_pkg::DELAY_RESET;
         phase     = '0;
         act_cmd   = i2cblm_pkg::CMD_START;
         running   = 1'b0;
         shreg     = '0;
         dly       = '0;
         ack_pick  = 1'b0;
         lines     = i2cblm_pkg::LINES_RESET;
         ack_got   = 1'b0;
         fails     = 0;
         n_done    = 0;
         n_rej     = 0;
         line_expect_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = line_rsp_type'(rsp_tdata);
            if (line_expect_q.size() == 0) begin
               report_mismatch("result with nothing outstanding", rsp_tdata, 16'h0);
            end else begin
               exp_r = line_expect_q.pop_front();
               if (got.scl !== exp_r.scl) report_mismatch("scl_out", got.scl, exp_r.scl);
               if (got.sda !== exp_r.sda) report_mismatch("sda_out", got.sda, exp_r.sda);
               if (got.oe !== exp_r.oe) report_mismatch("sda_drive", got.oe, exp_r.oe);
               if (got.busy !== exp_r.busy) report_mismatch("busy_res", got.busy, exp_r.busy);
               if (got.done !== exp_r.done) report_mismatch("done_res", got.done, exp_r.done);
               if (got.ack !== exp_r.ack) report_mismatch("ack_received", got.ack, exp_r.ack);
               if (got.rdata !== exp_r.rdata)
                  report_mismatch("read_data", got.rdata, exp_r.rdata);
               if (got.rejected !== exp_r.rejected)
                  report_mismatch("rejected", got.rejected, exp_r.rejected);
               if (got.pad !== 1'b0) report_mismatch("padding bit", got.pad, 1'b0);
            end
         end
         if (req_tvalid && req_tready) advance_engine(req_tuser, req_tdata);
         // a register write takes effect for the transactions after this edge
         if (csr_we) delay_cfg = csr_wdata;
      end
      fail_count   <= fails;
      pending      <= line_expect_q.size();
      engine_busy  <= running;
      done_count   <= n_done;
      reject_count <= n_rej;
   end

endmodule

[tb/sv/tb.sv]
// Top-level testbench for the I2C bit-level master: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb;

   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS   = 250;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic        csr_we;
   logic [15:0] csr_wdata;

   int          fail_count, pending, done_count, reject_count;
   logic        engine_busy;

   int          idle_pct, stall_pct, items_sent, quiet_cycles, hold_left;
   logic [15:0] cur_cfg;
   logic        hold_request, hold_taken;

   i2c_bit_level_master DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   i2cblm_checker checker_i (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .fail_count   (fail_count),
      .pending      (pending),
      .engine_busy  (engine_busy),
      .done_count   (done_count),
      .reject_count (reject_count)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // rsp side: random stalls, plus one long hold-off on request
   initial begin
      hold_left = 0;
      hold_taken = 1'b0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (!hold_request) hold_taken = 1'b0;
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("== FAIL ==");
         $finish;
      end
   end

   // valid stays high between back-to-back transactions
   task automatic send_item(input logic kind, input i2cblm_pkg::cmd_type c,
                            input logic [7:0] data_byte, input logic ack_sel,
                            input logic sda);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {4'b0000, sda, ack_sel, data_byte, c};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic send_tick(input logic sda);
      send_item(i2cblm_pkg::KIND_TICK, i2cblm_pkg::cmd_type'($urandom_range(3)),
                8'($urandom_range(255)), 1'($urandom_range(1)), sda);
   endtask

   // level a well-behaved slave puts on SDA during phase p
   function automatic logic slave_sda(input i2cblm_pkg::cmd_type c, input int p,
                                      input logic [7:0] rx, input logic slave_ack);
      if (c == i2cblm_pkg::CMD_WRITE && p == i2cblm_pkg::WR_ACK_HIGH) return ~slave_ack;
      if (c == i2cblm_pkg::CMD_READ && p > i2cblm_pkg::RD_RELEASE &&
          p < i2cblm_pkg::RD_ACK_DRIVE && p % 2 == 1)
         return rx[7 - (p - 1) / 2];
      return 1'($urandom_range(1));
   endfunction

   task automatic run_sequence(input i2cblm_pkg::cmd_type c, input logic [7:0] data_byte,
                               input logic ack_sel, input logic slave_ack, input logic noisy);
      int eff, total, cut, poke;
      eff = (cur_cfg == 16'd0) ? 1 : cur_cfg;
      case (c)
         i2cblm_pkg::CMD_WRITE: total = i2cblm_pkg::PHASES_WRITE * eff;
         i2cblm_pkg::CMD_READ:  total = i2cblm_pkg::PHASES_READ * eff;
         i2cblm_pkg::CMD_STOP:  total = i2cblm_pkg::PHASES_STOP * eff;
         default:               total = i2cblm_pkg::PHASES_START * eff;
      endcase
      cut = total;
      poke = -1;
      if (noisy) begin
         if ($urandom_range(99) < 6)
            repeat ($urandom_range(3, 1)) send_tick(1'($urandom_range(1)));
         if ($urandom_range(99) < 10) poke = $urandom_range(total - 1);
         if ($urandom_range(99) < 5) cut = $urandom_range(total - 1);
      end
      send_item(i2cblm_pkg::KIND_COMMAND, c, data_byte, ack_sel, 1'($urandom_range(1)));
      for (int t = 0; t < cut; t++) begin
         if (t == poke)
            send_item(i2cblm_pkg::KIND_COMMAND, i2cblm_pkg::cmd_type'($urandom_range(3)),
                      8'($urandom_range(255)), 1'($urandom_range(1)),
                      1'($urandom_range(1)));
         send_tick(slave_sda(c, t / eff, data_byte, slave_ack));
      end
   endtask

   // finish any running command and wait for every result
   task automatic settle();
      forever begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         if (engine_busy) send_tick(1'($urandom_range(1)));
         else if (pending == 0) break;
      end
   endtask

   task automatic write_delay(input logic [15:0] value);
      settle();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      cur_cfg = value;
   endtask

   task automatic random_traffic(input int n_items);
      int stop_at;
      stop_at = items_sent + n_items;
      while (items_sent < stop_at)
         run_sequence(i2cblm_pkg::cmd_type'($urandom_range(3)), 8'($urandom_range(255)),
                      1'($urandom_range(1)), $urandom_range(99) < 80, 1'b1);
   endtask

   initial begin
      reset        <= 1'b1;
      req_tvalid   <= 1'b0;
      req_tdata    <= '0;
      req_tuser    <= i2cblm_pkg::KIND_COMMAND;
      csr_we       <= 1'b0;
      csr_wdata    <= '0;
      hold_request <= 1'b0;
      stall_pct    <= 0;
      idle_pct = 0;
      items_sent = 0;
      cur_cfg = i2cblm_pkg::DELAY_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: idle tick, each command, ack and nack, extreme bytes, busy rejection
      send_tick(1'b0);
      run_sequence(i2cblm_pkg::CMD_START, 8'h00, 1'b0, 1'b1, 1'b0);
      run_sequence(i2cblm_pkg::CMD_WRITE, 8'hFF, 1'b0, 1'b1, 1'b0);
      run_sequence(i2cblm_pkg::CMD_WRITE, 8'h00, 1'b1, 1'b0, 1'b0);
      send_item(i2cblm_pkg::KIND_COMMAND, i2cblm_pkg::CMD_START, 8'hFF, 1'b1, 1'b1);
      send_item(i2cblm_pkg::KIND_COMMAND, i2cblm_pkg::CMD_STOP, 8'h00, 1'b0, 1'b0);
      repeat (i2cblm_pkg::PHASES_START) send_tick(1'b1);
      run_sequence(i2cblm_pkg::CMD_READ, 8'hFF, 1'b1, 1'b1, 1'b0);
      run_sequence(i2cblm_pkg::CMD_READ, 8'h00, 1'b0, 1'b1, 1'b0);
      run_sequence(i2cblm_pkg::CMD_READ, 8'h5A, 1'b1, 1'b1, 1'b0);
      run_sequence(i2cblm_pkg::CMD_STOP, 8'hA5, 1'b0, 1'b1, 1'b0);

      // no idling, with one long rsp hold-off and a full drain
      write_delay(16'd2);
      idle_pct = 0;
      stall_pct <= 0;
      hold_request <= 1'b1;
      run_sequence(i2cblm_pkg::CMD_WRITE, 8'($urandom_range(255)), 1'b1, 1'b1, 1'b0);
      hold_request <= 1'b0;
      settle();
      random_traffic(RANDOM_ITEMS);

      write_delay(16'd0);
      idle_pct = 74;
      stall_pct <= 0;
      random_traffic(RANDOM_ITEMS);

      write_delay(16'd3);
      idle_pct = 0;
      stall_pct <= 74;
      random_traffic(RANDOM_ITEMS);

      write_delay(16'd1);
      idle_pct = 10;
      stall_pct <= 10;
      random_traffic(RANDOM_ITEMS);

      // a long delay, one short command at full rate
      write_delay(16'd40);
      idle_pct = 0;
      stall_pct <= 0;
      run_sequence(i2cblm_pkg::CMD_START, 8'($urandom_range(255)), 1'b0, 1'b1, 1'b0);

      settle();
      repeat (10) @(posedge clock);
      $display("Run: %0d transactions sent, %0d commands completed, %0d commands rejected",
               items_sent, done_count, reject_count);
      $display("Delays 1, 2, 0, 3 and 40 under several idle and stall mixes");
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
